@@ sv/lpf_pkg.sv @@
// ---------------------------------------------------------------------------
// lpf_pkg: shared types and constants for the length-prefixed packet framer
// Holds the framing byte codes and the control groups passed between the
// sequencer and the row of message storage cells.
// ---------------------------------------------------------------------------
package lpf_pkg;

    // Framing bytes.
    localparam logic [7:0] LPF_PREAMBLE_BYTE = 8'hCC;
    localparam logic [7:0] LPF_START_BYTE    = 8'hAA;
    localparam logic [7:0] LPF_END_BYTE      = 8'h55;

    // Control from the sequencer to the whole cell row.
    typedef struct packed {
        logic store;   // a message byte is written this cycle
        logic shift;   // every cell takes its neighbor's byte this cycle
    } lpf_chain_ctl_t;

    // Control seen by one cell.
    typedef struct packed {
        logic load;    // this cell takes the incoming message byte
        logic shift;   // this cell takes the byte of the next cell
    } lpf_cell_ctl_t;

endpackage

@@ sv/lpf_cell.sv @@
// ---------------------------------------------------------------------------
// lpf_cell: one byte cell of the message storage row
// Loads a new message byte when selected, or takes the byte of the next cell
// toward the tail while the frame body is read out from the head.
// ---------------------------------------------------------------------------
module lpf_cell (
    input  logic                  clk,
    input  lpf_pkg::lpf_cell_ctl_t ctl,
    input  logic [7:0]            data_in,
    input  logic [7:0]            neighbor,
    output logic [7:0]            q
);
    import lpf_pkg::*;

    logic [7:0] byte_reg;

    // Payload storage; the contents are only read after being written.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            byte_reg <= data_in;
        end
        else if (ctl.shift)
        begin
            byte_reg <= neighbor;
        end
    end

    assign q = byte_reg;

endmodule

@@ sv/lpf_seq.sv @@
// ---------------------------------------------------------------------------
// lpf_seq: message collection and frame sequencer
// Counts incoming message bytes, keeps the additive checksum and drop flag,
// and, unless stalled, puts one frame byte per cycle into an output register.
// ---------------------------------------------------------------------------
module lpf_seq #(
    parameter int MAX_MESSAGE_BYTES = 56,
    parameter int PREAMBLE_COUNT    = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              msg_valid,
    output logic                              msg_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              carries_byte,
    input  logic                              message_end,
    input  logic [7:0]                        head_byte,
    output lpf_pkg::lpf_chain_ctl_t           chain,
    output logic [$clog2(MAX_MESSAGE_BYTES+1)-1:0] count,
    output logic                              frame_valid,
    input  logic                              frame_stall,
    output logic [7:0]                        frame_byte,
    output logic                              frame_last,
    output logic                              overflow
);
    import lpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int PRE_W = $clog2(PREAMBLE_COUNT + 1);

    typedef enum logic [6:0] {
        S_COLLECT = 7'b0000001,
        S_PRE     = 7'b0000010,
        S_START   = 7'b0000100,
        S_LEN     = 7'b0001000,
        S_DATA    = 7'b0010000,
        S_SUM     = 7'b0100000,
        S_END     = 7'b1000000
    } seq_state_t;

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic             drop_reg, drop_next;
    logic [PRE_W-1:0] pre_reg, pre_next;
    logic             ov_reg, ov_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             ovf_reg, ovf_next;
    logic             accept;
    logic             out_free;

    assign msg_stall = (state_reg != S_COLLECT);
    assign accept    = msg_valid && (state_reg == S_COLLECT);
    assign out_free  = !ov_reg || !frame_stall;

    // Next-state logic for collection and frame emission.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        drop_next   = drop_reg;
        pre_next    = pre_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        ovf_next    = ovf_reg;
        ov_next     = ov_reg && frame_stall;
        chain.store = 1'b0;
        chain.shift = 1'b0;

        case (state_reg)
            S_COLLECT:
            begin
                if (accept)
                begin
                    if (carries_byte)
                    begin
                        if (count_reg < CNT_W'(MAX_MESSAGE_BYTES))
                        begin
                            chain.store = 1'b1;
                            count_next  = count_reg + 1'b1;
                            sum_next    = sum_reg + data_byte;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    if (message_end)
                    begin
                        state_next = S_PRE;
                        pre_next   = PRE_W'(PREAMBLE_COUNT - 1);
                    end
                end
            end
            S_PRE:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    byte_next = LPF_PREAMBLE_BYTE;
                    last_next = 1'b0;
                    ovf_next  = drop_reg;
                    if (pre_reg == '0)
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        pre_next = pre_reg - 1'b1;
                    end
                end
            end
            S_START:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    byte_next  = LPF_START_BYTE;
                    last_next  = 1'b0;
                    ovf_next   = drop_reg;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    byte_next  = 8'(count_reg);
                    last_next  = 1'b0;
                    ovf_next   = drop_reg;
                    state_next = (count_reg == '0) ? S_SUM : S_DATA;
                end
            end
            S_DATA:
            begin
                // The count now serves as the number of body bytes still to go.
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    byte_next   = head_byte;
                    last_next   = 1'b0;
                    ovf_next    = drop_reg;
                    chain.shift = 1'b1;
                    count_next  = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    byte_next  = sum_reg;
                    last_next  = 1'b0;
                    ovf_next   = drop_reg;
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    byte_next  = LPF_END_BYTE;
                    last_next  = 1'b1;
                    ovf_next   = drop_reg;
                    count_next = '0;
                    sum_next   = '0;
                    drop_next  = 1'b0;
                    state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            count_reg <= '0;
            sum_reg   <= '0;
            drop_reg  <= 1'b0;
            pre_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            drop_reg  <= drop_next;
            pre_reg   <= pre_next;
            ov_reg    <= ov_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

    assign count       = count_reg;
    assign frame_valid = ov_reg;
    assign frame_byte  = byte_reg;
    assign frame_last  = last_reg;
    assign overflow    = ovf_reg;

endmodule

@@ sv/length_prefixed_packet_framer.sv @@
// ---------------------------------------------------------------------------
// length_prefixed_packet_framer: top level of the packet framer
// Collects a message into a row of byte cells and emits it framed by a
// preamble, start byte, length, checksum and end byte.
// ---------------------------------------------------------------------------
// Channel   Handshake                Payload
// message   msg_valid / msg_stall    data_byte, carries_byte, message_end
// frame     frame_valid / frame_stall frame_byte, frame_last, overflow
//
// A message request without the end mark leaves the input open for the next.
// A request with the end mark starts a frame of PREAMBLE_COUNT + 4 + n bytes,
// n the stored length; one byte leaves per cycle while frame_stall is low,
// the body being shifted out of the cell row from its head.
// msg_stall stays high from that request until the end byte is in the output
// register; a stall on the frame side holds the sequencer in place.
// Reset clears the count, checksum, drop flag and output valid.
// ---------------------------------------------------------------------------
module length_prefixed_packet_framer #(
    parameter int MAX_MESSAGE_BYTES = 56,
    parameter int PREAMBLE_COUNT    = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    output logic       msg_stall,
    input  logic [7:0] data_byte,
    input  logic       carries_byte,
    input  logic       message_end,
    output logic       frame_valid,
    input  logic       frame_stall,
    output logic [7:0] frame_byte,
    output logic       frame_last,
    output logic       overflow
);
    import lpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);

    lpf_chain_ctl_t   chain;
    logic [CNT_W-1:0] count;
    lpf_cell_ctl_t    cell_ctl [MAX_MESSAGE_BYTES];
    logic [7:0]       cell_q   [MAX_MESSAGE_BYTES];

    // Collection and frame sequencing.
    lpf_seq #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
        .PREAMBLE_COUNT    (PREAMBLE_COUNT)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .data_byte    (data_byte),
        .carries_byte (carries_byte),
        .message_end  (message_end),
        .head_byte    (cell_q[0]),
        .chain        (chain),
        .count        (count),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_byte   (frame_byte),
        .frame_last   (frame_last),
        .overflow     (overflow)
    );

    // Row of byte cells; a new byte lands in the cell at the current count,
    // and read-out shifts every cell one place toward the head.
    for (genvar i = 0; i < MAX_MESSAGE_BYTES; i++)
    begin : g_cell
        assign cell_ctl[i] = '{load:  chain.store && (count == CNT_W'(i)),
                               shift: chain.shift};

        if (i == MAX_MESSAGE_BYTES - 1)
        begin : g_tail
            lpf_cell u_cell (
                .clk      (clk),
                .ctl      (cell_ctl[i]),
                .data_in  (data_byte),
                .neighbor (8'h00),
                .q        (cell_q[i])
            );
        end
        else
        begin : g_body
            lpf_cell u_cell (
                .clk      (clk),
                .ctl      (cell_ctl[i]),
                .data_in  (data_byte),
                .neighbor (cell_q[i+1]),
                .q        (cell_q[i])
            );
        end
    end

endmodule

@@ sv/lpf_checker.sv @@
// ---------------------------------------------------------------------------
// lpf_checker: port-level checks for the packet framer
// Watches both channels and flags frame and handshake ordering errors.
// ---------------------------------------------------------------------------
module lpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       msg_valid,
    input logic       msg_stall,
    input logic       message_end,
    input logic       frame_valid,
    input logic       frame_stall,
    input logic [7:0] frame_byte,
    input logic       frame_last
);
    import lpf_pkg::*;

    // The closing byte of a frame is always the end code.
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_last |-> frame_byte == LPF_END_BYTE)
        else $error("frame_last set on a byte other than the end code");

    // A held frame byte keeps its value.
    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_stall |=> frame_valid && $stable(frame_byte))
        else $error("stalled frame byte changed");

    // Once a message is closed, the block is busy emitting its frame.
    a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_stall && message_end |=> msg_stall)
        else $error("message request taken right after a closing request");

    // A request that does not close the message leaves the input open.
    a_open_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_stall && !message_end |=> !msg_stall)
        else $error("input stalled after a request without the end mark");

endmodule

bind length_prefixed_packet_framer lpf_checker u_lpf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .message_end (message_end),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_byte  (frame_byte),
    .frame_last  (frame_last)
);

@@ tb/tb_length_prefixed_packet_framer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_length_prefixed_packet_framer: self-checking bench for the packet framer
// Feeds message requests through the valid/stall handshake and predicts every
// frame byte (preamble, start, length, body, checksum, end) with the last and
// overflow flags. Empty, full and overflowing messages are covered. Random
// idling and back-pressure appear on both sides, with one calm stretch.
// ---------------------------------------------------------------------------
module tb_length_prefixed_packet_framer;

    import lpf_pkg::*;

    localparam int MAX_MESSAGE_BYTES = 56;
    localparam int PREAMBLE_COUNT    = 4;
    localparam int TARGET_REQUESTS   = 450;
    localparam int CYCLE_LIMIT       = 300000;
    localparam int DRAIN_CYCLES      = 16;
    localparam int IDLE_PERCENT      = 12;
    localparam int CALM_FIRST        = 150;
    localparam int CALM_LAST         = 260;

    // One message request as presented on the input side.
    typedef struct {
        logic [7:0] data;
        logic       carries;
        logic       last_of_msg;
        bit         wait_drain;   // hold until every frame byte has come back
    } msg_req_t;

    // One frame byte as it should leave the block.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       lost;
    } frame_beat_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       msg_valid    = 1'b0;
    logic       msg_stall;
    logic [7:0] data_byte    = 8'h00;
    logic       carries_byte = 1'b0;
    logic       message_end  = 1'b0;
    logic       frame_valid;
    logic       frame_stall  = 1'b0;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       overflow;

    msg_req_t    pending_reqs[$];
    msg_req_t    cur_req;
    frame_beat_t frame_bytes_due[$];

    // Shadow of the message being collected.
    logic [7:0] body_bytes[$];
    logic [7:0] body_sum  = 8'h00;
    bit         body_lost = 1'b0;

    int requests_taken  = 0;
    int mismatches      = 0;
    int bytes_checked   = 0;
    int frames_checked  = 0;
    int lost_frames     = 0;
    int longest_body    = 0;
    int cycle_count     = 0;
    bit calm;

    length_prefixed_packet_framer #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
        .PREAMBLE_COUNT    (PREAMBLE_COUNT)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .data_byte    (data_byte),
        .carries_byte (carries_byte),
        .message_end  (message_end),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_byte   (frame_byte),
        .frame_last   (frame_last),
        .overflow     (overflow)
    );

    always #5 clk = ~clk;

    // Neither side idles during this window of requests.
    assign calm = (requests_taken >= CALM_FIRST) && (requests_taken < CALM_LAST);

    // Store a byte or close the message and queue the whole frame.
    task automatic collect_and_frame(input msg_req_t r);
        frame_beat_t beat;
        if (r.carries)
        begin
            if (body_bytes.size() < MAX_MESSAGE_BYTES)
            begin
                body_bytes.insert(body_bytes.size(), r.data);
                body_sum = body_sum + r.data;
            end
            else
            begin
                body_lost = 1'b1;
            end
        end
        if (r.last_of_msg)
        begin
            beat.last = 1'b0;
            beat.lost = body_lost;
            beat.value = LPF_PREAMBLE_BYTE;
            repeat (PREAMBLE_COUNT) frame_bytes_due.insert(frame_bytes_due.size(), beat);
            beat.value = LPF_START_BYTE;
            frame_bytes_due.insert(frame_bytes_due.size(), beat);
            beat.value = 8'(body_bytes.size());
            frame_bytes_due.insert(frame_bytes_due.size(), beat);
            foreach (body_bytes[i])
            begin
                beat.value = body_bytes[i];
                frame_bytes_due.insert(frame_bytes_due.size(), beat);
            end
            beat.value = body_sum;
            frame_bytes_due.insert(frame_bytes_due.size(), beat);
            beat.value = LPF_END_BYTE;
            beat.last = 1'b1;
            frame_bytes_due.insert(frame_bytes_due.size(), beat);
            if (body_lost)
                lost_frames++;
            if (body_bytes.size() > longest_body)
                longest_body = body_bytes.size();
            body_bytes.delete();
            body_sum = 8'h00;
            body_lost = 1'b0;
        end
    endtask

    task automatic queue_request(input logic [7:0] data, input logic carries,
                                 input logic last_of_msg, input bit wait_drain);
        msg_req_t r;
        r.data = data;
        r.carries = carries;
        r.last_of_msg = last_of_msg;
        r.wait_drain = wait_drain;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Request driver: predicts on acceptance, then presents the next request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            data_byte <= 8'h00;
            carries_byte <= 1'b0;
            message_end <= 1'b0;
        end
        else
        begin
            if (msg_valid && !msg_stall)
            begin
                collect_and_frame(cur_req);
                requests_taken <= requests_taken + 1;
            end
            if (!msg_valid || !msg_stall)
            begin
                if (pending_reqs.size() > 0
                    && !(pending_reqs[0].wait_drain && frame_bytes_due.size() != 0)
                    && (calm || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    cur_req = pending_reqs.pop_front();
                    msg_valid <= 1'b1;
                    data_byte <= cur_req.data;
                    carries_byte <= cur_req.carries;
                    message_end <= cur_req.last_of_msg;
                end
                else
                begin
                    msg_valid <= 1'b0;
                end
            end
        end
    end

    // Frame monitor: checks each accepted byte and applies random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t due;
        if (!rst_n)
        begin
            frame_stall <= 1'b0;
        end
        else
        begin
            if (frame_valid && !frame_stall)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected frame byte %02h last %b overflow %b",
                             $time, frame_byte, frame_last, overflow);
                    mismatches++;
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    bytes_checked++;
                    if (frame_byte !== due.value)
                    begin
                        $display("%0t: frame_byte expected %02h actual %02h",
                                 $time, due.value, frame_byte);
                        mismatches++;
                    end
                    if (frame_last !== due.last)
                    begin
                        $display("%0t: frame_last expected %b actual %b",
                                 $time, due.last, frame_last);
                        mismatches++;
                    end
                    if (overflow !== due.lost)
                    begin
                        $display("%0t: overflow expected %b actual %b",
                                 $time, due.lost, overflow);
                        mismatches++;
                    end
                    if (due.last)
                        frames_checked++;
                end
            end
            frame_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d requests and %0d frame bytes outstanding",
                     $time, pending_reqs.size(), frame_bytes_due.size());
            $display("** length_prefixed_packet_framer: FAILED **");
            $finish;
        end
    end

    // Stimulus: directed messages, then random well-formed messages with noise.
    initial
    begin
        int counted;
        int msg_num;
        int body_len;
        int pick;
        bit end_has_byte;

        // Empty message: an end with no byte; the data lines are ignored.
        queue_request(8'hFF, 1'b0, 1'b1, 1'b0);
        // Single zero byte arriving together with the end.
        queue_request(8'h00, 1'b1, 1'b1, 1'b0);
        // Checksum wraps past 255; the closing end carries no byte.
        queue_request(8'hFF, 1'b1, 1'b0, 1'b0);
        queue_request(8'hFF, 1'b1, 1'b0, 1'b0);
        queue_request(8'h80, 1'b1, 1'b0, 1'b0);
        queue_request(8'h5A, 1'b0, 1'b1, 1'b0);
        // A request with neither byte nor end produces nothing.
        queue_request(8'hA5, 1'b0, 1'b0, 1'b0);
        queue_request(8'h01, 1'b1, 1'b0, 1'b0);
        queue_request(8'h7F, 1'b1, 1'b1, 1'b0);
        // After a full drain, a body that mimics the framing bytes.
        queue_request(LPF_START_BYTE, 1'b1, 1'b0, 1'b1);
        queue_request(LPF_END_BYTE, 1'b1, 1'b0, 1'b0);
        queue_request(LPF_PREAMBLE_BYTE, 1'b1, 1'b1, 1'b0);
        counted = 12;

        msg_num = 0;
        while (counted < TARGET_REQUESTS)
        begin
            // Mostly short bodies, some long, some exactly full, some overflowing.
            pick = $urandom_range(99);
            if (msg_num == 0)
                body_len = MAX_MESSAGE_BYTES;
            else if (msg_num == 1)
                body_len = MAX_MESSAGE_BYTES + 5;
            else if (pick < 70)
                body_len = $urandom_range(12);
            else if (pick < 85)
                body_len = $urandom_range(MAX_MESSAGE_BYTES - 1, 13);
            else if (pick < 93)
                body_len = MAX_MESSAGE_BYTES;
            else
                body_len = $urandom_range(MAX_MESSAGE_BYTES + 8, MAX_MESSAGE_BYTES + 1);
            end_has_byte = (body_len > 0) && (msg_num == 1 || $urandom_range(1) == 1);

            for (int i = 0; i < body_len - (end_has_byte ? 1 : 0); i++)
            begin
                if ($urandom_range(99) < 5)
                    queue_request(8'($urandom), 1'b0, 1'b0, 1'b0);
                queue_request(8'($urandom), 1'b1, 1'b0,
                              (i == 0) && (msg_num % 15 == 7));
                counted++;
            end
            queue_request(8'($urandom), end_has_byte, 1'b1,
                          (body_len == 0) && (msg_num % 15 == 7));
            counted++;
            msg_num++;
        end

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || msg_valid || frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (frame_bytes_due.size() != 0)
        begin
            $display("%0t: %0d frame bytes never arrived", $time, frame_bytes_due.size());
            mismatches++;
        end
        $display("Run covered %0d requests, %0d frames and %0d frame bytes checked.",
                 requests_taken, frames_checked, bytes_checked);
        $display("Frames with dropped bytes: %0d; longest stored body: %0d bytes.",
                 lost_frames, longest_body);
        if (mismatches == 0)
            $display("** length_prefixed_packet_framer: PASSED **");
        else
            $display("** length_prefixed_packet_framer: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
sv/lpf_pkg.sv
sv/lpf_cell.sv
sv/lpf_seq.sv
sv/length_prefixed_packet_framer.sv
sv/lpf_checker.sv
tb/tb_length_prefixed_packet_framer.sv
